// File: design/lzw_byte_compressor_assert.svh
// Assertion macros for the LZW byte compressor.
`ifndef LZW_BYTE_COMPRESSOR_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LZWC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzwc assertion failed");
`define LZWC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzwc assertion failed");
`else
`define LZWC_ASSERT_IMP(label, ante, cons)
`define LZWC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: design/lzwc_pkg.sv
`timescale 1ns / 1ps
package lzwc_pkg;
    localparam int MAX_CODES  = 4096;
    localparam int TABLE_DEPTH = 4096;
    localparam int TABLE_AW   = 12;
    localparam int CODE_W     = 12;
    localparam int NCODE_W    = 13;
    localparam int KEY_W      = 20;
    localparam int EPOCH_W    = 4;
    localparam logic [NCODE_W-1:0] FIRST_FREE = 13'd256;
    localparam logic [NCODE_W-1:0] DICT_LIMIT = NCODE_W'(MAX_CODES);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};

    typedef struct packed {
        logic               valid;
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [TABLE_AW-1:0] hash_key(input logic [KEY_W-1:0] k);
        return k[19:8] ^ {k[3:0], k[7:0]};
    endfunction
endpackage

// File: design/lzw_byte_compressor.sv
`timescale 1ns / 1ps
// LZW compressor: bytes in, 12-bit codes out, one code per beat. A byte that
// extends the prefix is accepted with a table read, then compared in ST_PROBE,
// which reads on for every extra probe of the hash table; a byte that ends a
// match goes to ST_MISS to emit and insert, the insert moving to ST_INSERT
// when the dictionary refills. The table is one 4096-entry RAM with one read
// and one write port. After reset, and on every 16th dictionary clear, a sweep
// clears all 4096 entries while no byte is taken.
module lzw_byte_compressor
    import lzwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic        m_axis_tlast    // end_of_stream
);
`include "lzw_byte_compressor_assert.svh"

    typedef enum logic [2:0] {
        ST_SWEEP, ST_IDLE, ST_PROBE, ST_MISS, ST_INSERT, ST_LAST
    } state_t;

    state_t                state_reg, state_next;
    logic [CODE_W-1:0]     prefix_reg, prefix_next;
    logic                  have_reg, have_next;
    logic [NCODE_W-1:0]    ncode_reg, ncode_next;
    logic [EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic                  last_reg, last_next;
    logic [TABLE_AW-1:0]   addr_reg, addr_next;
    logic                  to_insert_reg, to_insert_next;
    logic                  ovalid_reg, ovalid_next;
    logic [CODE_W-1:0]     ocode_reg, ocode_next;
    logic                  olast_reg, olast_next;

    logic                  wr_en, rd_en, out_free, slot_live;
    logic [TABLE_AW-1:0]   wr_addr, rd_addr;
    entry_t                wr_data, rd_data;
    logic [ENTRY_W-1:0]    rd_raw;

    lzwc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data   = entry_t'(rd_raw);
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign slot_live = rd_data.valid && (rd_data.epoch == epoch_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'b0000, ocode_reg};
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        have_next      = have_reg;
        ncode_next     = ncode_reg;
        epoch_next     = epoch_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        to_insert_next = to_insert_reg;
        ovalid_next    = ovalid_reg && !m_axis_tready;
        ocode_next     = ocode_reg;
        olast_next     = olast_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == {TABLE_AW{1'b1}})
                begin
                    state_next = to_insert_reg ? ST_INSERT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    if (!have_reg)
                    begin
                        prefix_next = {4'b0000, s_axis_tdata};
                        have_next   = 1'b1;
                        state_next  = s_axis_tlast ? ST_LAST : ST_IDLE;
                    end
                    else
                    begin
                        key_next   = {prefix_reg, s_axis_tdata};
                        rd_en      = 1'b1;
                        rd_addr    = hash_key({prefix_reg, s_axis_tdata});
                        addr_next  = rd_addr;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (slot_live && rd_data.key == key_reg)
                begin
                    prefix_next = rd_data.code;
                    state_next  = last_reg ? ST_LAST : ST_IDLE;
                end
                else if (slot_live)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                    addr_next = rd_addr;
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = prefix_reg;
                    olast_next  = 1'b0;
                    prefix_next = {4'b0000, key_reg[7:0]};
                    if (ncode_reg >= DICT_LIMIT)
                    begin
                        ncode_next = FIRST_FREE;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            epoch_next     = '0;
                            addr_next      = '0;
                            to_insert_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                            state_next = ST_INSERT;
                        end
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = '{valid: 1'b1, epoch: epoch_reg, key: key_reg,
                                       code: ncode_reg[CODE_W-1:0]};
                        ncode_next = ncode_reg + 1'b1;
                        state_next = last_reg ? ST_LAST : ST_IDLE;
                    end
                end
            end
            ST_INSERT:
            begin
                wr_en      = 1'b1;
                wr_addr    = hash_key(key_reg);
                wr_data    = '{valid: 1'b1, epoch: epoch_reg, key: key_reg,
                               code: ncode_reg[CODE_W-1:0]};
                ncode_next = ncode_reg + 1'b1;
                state_next = last_reg ? ST_LAST : ST_IDLE;
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocode_next  = prefix_reg;
                    olast_next  = 1'b1;
                    prefix_next = '0;
                    have_next   = 1'b0;
                    ncode_next  = FIRST_FREE;
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        epoch_next     = '0;
                        addr_next      = '0;
                        to_insert_next = 1'b0;
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            prefix_reg    <= '0;
            have_reg      <= 1'b0;
            ncode_reg     <= FIRST_FREE;
            epoch_reg     <= '0;
            last_reg      <= 1'b0;
            addr_reg      <= '0;
            to_insert_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            olast_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            have_reg      <= have_next;
            ncode_reg     <= ncode_next;
            epoch_reg     <= epoch_next;
            last_reg      <= last_next;
            addr_reg      <= addr_next;
            to_insert_reg <= to_insert_next;
            ovalid_reg    <= ovalid_next;
            olast_reg     <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        ocode_reg <= ocode_next;
    end

    `LZWC_ASSERT_IMP(a_ncode_range, 1'b1, ncode_reg >= FIRST_FREE && ncode_reg <= DICT_LIMIT)
    `LZWC_ASSERT_IMP(a_no_write_probe, state_reg == ST_PROBE, !wr_en)
    `LZWC_ASSERT_NXT(a_last_clears, state_reg == ST_LAST && out_free, !have_reg)
    `LZWC_ASSERT_NXT(a_last_flags, state_reg == ST_LAST && out_free, m_axis_tvalid && m_axis_tlast)
endmodule

// File: design/lzwc_ram.sv
`timescale 1ns / 1ps
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
